// ===== rtl/plids_pkg.sv =====
`timescale 1ns / 1ps
// Package for the positional list unit: codes, field widths and the control
// structs passed between the controller, the top level and the list cells.
package plids_pkg;

	localparam int unsigned DEPTH_DEF = 16;

	localparam int unsigned VALUE_W = 32;
	localparam int unsigned OP_W    = 2;
	localparam int unsigned POS_W   = 5;
	localparam int unsigned STAT_W  = 2;
	localparam int unsigned FOUND_W = 4;
	localparam int unsigned LEN_W   = 5;

	localparam logic [OP_W-1:0] OP_INSERT = 2'd0;
	localparam logic [OP_W-1:0] OP_DELETE = 2'd1;
	localparam logic [OP_W-1:0] OP_SEARCH = 2'd2;

	localparam logic [STAT_W-1:0] ST_OK       = 2'd0;
	localparam logic [STAT_W-1:0] ST_RANGE    = 2'd1;
	localparam logic [STAT_W-1:0] ST_FULL     = 2'd2;
	localparam logic [STAT_W-1:0] ST_NOTFOUND = 2'd3;

	typedef logic signed [VALUE_W-1:0] value_t;

	// Broadcast from the controller to the whole chain.
	typedef struct packed {
		logic ins_ok;    // accepted insert that changes the list
		logic del_ok;    // accepted delete that changes the list
		logic load_hit;  // accepted search: every cell latches its compare
		logic shift_hit; // search scan: hit flags move one cell toward the head
	} chain_op_t;

	// Per-cell decode of the broadcast.
	typedef struct packed {
		logic take_val;   // load the request value
		logic take_left;  // take the entry of the cell before
		logic take_right; // take the entry of the cell after
		logic load_hit;
		logic shift_hit;
		logic in_use;     // cell lies below the current length
	} cell_ctl_t;

endpackage

// ===== rtl/positional_list_insert_delete_search_unit.sv =====
`timescale 1ns / 1ps
// Top level of the positional list unit: a chain of list cells and the
// controller. Depends on plids_pkg, plids_cell and plids_ctrl.
//
// Usage: every request on the input channel (in_valid/in_ready) carries an
// opcode, a value and a position, and gives exactly one result on the output
// channel (out_valid/out_ready) with a status, a found position and the
// list length after the request. The list lives in a row of DEPTH cells;
// cell i holds entry i. An insert or delete moves the cells from the
// position on: each loads the request value or the entry of its left or right
// neighbor. For insert, delete, rejected and unused requests the result is
// registered at the accepting edge, so one request per cycle is sustained
// while the receiver keeps out_ready high.
// A search latches a compare flag in every cell, then shifts the flags
// toward the head one cell per cycle while a counter walks the positions.
// The counter gives the match position when a flag reaches the head; a miss
// ends the scan at the length. No request is taken during the scan.
// Reset empties the list (length zero) and clears both channels; entry data
// is not cleared. While the receiver stalls, the result is held and a new
// request is taken only in the cycle the held result is consumed.
module positional_list_insert_delete_search_unit #(
	parameter int unsigned DEPTH = plids_pkg::DEPTH_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           in_valid,
	output logic                           in_ready,
	input  logic [plids_pkg::OP_W-1:0]     opcode,
	input  plids_pkg::value_t              item_value,
	input  logic [plids_pkg::POS_W-1:0]    position,
	output logic                           out_valid,
	input  logic                           out_ready,
	output logic [plids_pkg::STAT_W-1:0]   status,
	output logic [plids_pkg::FOUND_W-1:0]  found_position,
	output logic [plids_pkg::LEN_W-1:0]    list_length
);
	import plids_pkg::*;

	localparam int unsigned CNT_W = $clog2(DEPTH + 1);
	localparam int unsigned IDX_W = (CNT_W > POS_W) ? CNT_W : POS_W;
	localparam logic [LEN_W-1:0] DEPTH_LEN = LEN_W'(DEPTH);

	logic [CNT_W-1:0] count;
	chain_op_t        op;
	logic             busy;
	value_t           entry [DEPTH];
	logic [DEPTH-1:0] hit;
	logic [IDX_W-1:0] pos_ext;
	logic [IDX_W-1:0] cnt_ext;

	assign pos_ext = IDX_W'(position);
	assign cnt_ext = IDX_W'(count);

	plids_ctrl #(
		.DEPTH (DEPTH),
		.CNT_W (CNT_W)
	) u_ctrl (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (in_valid),
		.in_ready       (in_ready),
		.opcode         (opcode),
		.position       (position),
		.head_hit       (hit[0]),
		.count          (count),
		.op             (op),
		.busy           (busy),
		.out_valid      (out_valid),
		.out_ready      (out_ready),
		.status         (status),
		.found_position (found_position),
		.list_length    (list_length)
	);

	// Each cell decodes the broadcast against its own place in the row.
	// Cells past the length may pick up stale data; they are written again
	// before the length grows over them.
	for (genvar i = 0; i < DEPTH; i++) begin : g_cell
		localparam logic [IDX_W-1:0] IDX = IDX_W'(i);
		cell_ctl_t ctl;
		value_t    left_value;
		value_t    right_value;
		logic      right_hit;

		assign ctl.take_val   = op.ins_ok && (IDX == pos_ext);
		assign ctl.take_left  = op.ins_ok && (IDX > pos_ext);
		assign ctl.take_right = op.del_ok && (IDX >= pos_ext);
		assign ctl.load_hit   = op.load_hit;
		assign ctl.shift_hit  = op.shift_hit;
		assign ctl.in_use     = IDX < cnt_ext;

		if (i == 0) begin : g_head
			assign left_value = entry[i];
		end else begin : g_body
			assign left_value = entry[i-1];
		end

		if (i == DEPTH - 1) begin : g_tail
			assign right_value = entry[i];
			assign right_hit   = 1'b0;
		end else begin : g_next
			assign right_value = entry[i+1];
			assign right_hit   = hit[i+1];
		end

		plids_cell u_cell (
			.clk         (clk),
			.arst_n      (arst_n),
			.ctl         (ctl),
			.item_value  (item_value),
			.left_value  (left_value),
			.right_value (right_value),
			.right_hit   (right_hit),
			.entry       (entry[i]),
			.hit         (hit[i])
		);
	end

	// No request may be taken while a search scan is running.
	a_busy_blocks_input: assert property (@(posedge clk) disable iff (!arst_n)
		busy |-> !in_ready)
		else $error("request accepted during search scan");

	// A full status is only reported when the list holds DEPTH entries.
	a_full_length: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && (status == ST_FULL)) |-> (list_length == DEPTH_LEN))
		else $error("full status with short list");

	// The found position is zero unless a search succeeded.
	a_found_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && (status != ST_OK)) |-> (found_position == '0))
		else $error("found position set on a failed request");

	// The length count never exceeds the number of cells.
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		1'b1 |-> (count <= CNT_W'(DEPTH)))
		else $error("length count beyond depth");

endmodule

// ===== rtl/plids_cell.sv =====
`timescale 1ns / 1ps
// One list cell: holds one entry and one search hit flag.
// Depends on plids_pkg.
module plids_cell (
	input  logic                clk,
	input  logic                arst_n,
	input  plids_pkg::cell_ctl_t ctl,
	input  plids_pkg::value_t   item_value,
	input  plids_pkg::value_t   left_value,
	input  plids_pkg::value_t   right_value,
	input  logic                right_hit,
	output plids_pkg::value_t   entry,
	output logic                hit
);
	import plids_pkg::*;

	value_t entry_q;
	logic   hit_q;

	always_ff @(posedge clk) begin
		priority if (ctl.take_val) begin
			entry_q <= item_value;
		end else if (ctl.take_left) begin
			entry_q <= left_value;
		end else if (ctl.take_right) begin
			entry_q <= right_value;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hit_q <= 1'b0;
		end else if (ctl.load_hit) begin
			hit_q <= ctl.in_use && (entry_q == item_value);
		end else if (ctl.shift_hit) begin
			hit_q <= right_hit;
		end
	end

	assign entry = entry_q;
	assign hit   = hit_q;

endmodule

// ===== rtl/plids_ctrl.sv =====
`timescale 1ns / 1ps
// Controller: length count, range checks, search scan sequencer and the
// result register. Depends on plids_pkg.
module plids_ctrl #(
	parameter int unsigned DEPTH = plids_pkg::DEPTH_DEF,
	parameter int unsigned CNT_W = $clog2(DEPTH + 1)
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         in_valid,
	output logic                         in_ready,
	input  logic [plids_pkg::OP_W-1:0]   opcode,
	input  logic [plids_pkg::POS_W-1:0]  position,
	input  logic                         head_hit,
	output logic [CNT_W-1:0]             count,
	output plids_pkg::chain_op_t         op,
	output logic                         busy,
	output logic                         out_valid,
	input  logic                         out_ready,
	output logic [plids_pkg::STAT_W-1:0] status,
	output logic [plids_pkg::FOUND_W-1:0] found_position,
	output logic [plids_pkg::LEN_W-1:0]  list_length
);
	import plids_pkg::*;

	localparam int unsigned CMP_W = (CNT_W > POS_W) ? CNT_W : POS_W;
	localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

	localparam logic S_IDLE = 1'b0;
	localparam logic S_SCAN = 1'b1;

	logic              state_q;
	logic [CNT_W-1:0]  count_q;
	logic [CNT_W-1:0]  scan_q;
	logic              out_valid_q;
	logic [STAT_W-1:0] status_q;
	logic [FOUND_W-1:0] found_q;
	logic [LEN_W-1:0]  length_q;

	logic              accept;
	logic [CMP_W-1:0]  pos_ext;
	logic [CMP_W-1:0]  cnt_ext;
	logic [CMP_W-1:0]  scan_ext;
	logic [CMP_W-1:0]  next_cnt_ext;
	logic              ins_range;
	logic              is_full;
	logic              del_range;
	logic              scan_miss;
	logic              scan_done;
	logic [STAT_W-1:0] new_status;
	logic [CNT_W-1:0]  new_count;

	assign in_ready = (state_q == S_IDLE) && (!out_valid_q || out_ready);
	assign accept   = in_valid && in_ready;

	assign pos_ext   = CMP_W'(position);
	assign cnt_ext   = CMP_W'(count_q);
	assign scan_ext  = CMP_W'(scan_q);
	assign ins_range = pos_ext > cnt_ext;
	assign is_full   = count_q == FULL_CNT;
	assign del_range = pos_ext >= cnt_ext;

	assign scan_miss = scan_q == count_q;
	assign scan_done = (state_q == S_SCAN) && (scan_miss || head_hit);

	always_comb begin
		new_status = ST_OK;
		new_count  = count_q;
		op         = '0;
		unique case (opcode)
			OP_INSERT: begin
				if (ins_range) begin
					new_status = ST_RANGE;
				end else if (is_full) begin
					new_status = ST_FULL;
				end else begin
					new_count = count_q + CNT_W'(1);
					op.ins_ok = accept;
				end
			end
			OP_DELETE: begin
				if (del_range) begin
					new_status = ST_RANGE;
				end else begin
					new_count = count_q - CNT_W'(1);
					op.del_ok = accept;
				end
			end
			OP_SEARCH: begin
				op.load_hit = accept;
			end
			default: begin
			end
		endcase
		op.shift_hit = (state_q == S_SCAN) && !scan_done;
	end

	assign next_cnt_ext = CMP_W'(new_count);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			count_q     <= '0;
			scan_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (accept) begin
				count_q <= new_count;
			end
			unique case (state_q)
				S_IDLE: begin
					if (accept && (opcode == OP_SEARCH)) begin
						state_q <= S_SCAN;
						scan_q  <= '0;
					end
				end
				S_SCAN: begin
					if (scan_done) begin
						state_q <= S_IDLE;
					end else begin
						scan_q <= scan_q + CNT_W'(1);
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
			if ((accept && (opcode != OP_SEARCH)) || scan_done) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept && (opcode != OP_SEARCH)) begin
			status_q <= new_status;
			found_q  <= '0;
			length_q <= next_cnt_ext[LEN_W-1:0];
		end else if (scan_done) begin
			status_q <= scan_miss ? ST_NOTFOUND : ST_OK;
			found_q  <= scan_miss ? '0 : scan_ext[FOUND_W-1:0];
			length_q <= cnt_ext[LEN_W-1:0];
		end
	end

	assign count          = count_q;
	assign busy           = state_q == S_SCAN;
	assign out_valid      = out_valid_q;
	assign status         = status_q;
	assign found_position = found_q;
	assign list_length    = length_q;

endmodule

// ===== tb/list_result_checker.sv =====
`timescale 1ns / 1ps
// Result checker for the positional list unit: keeps a shadow list, predicts the
// result of every accepted request and compares it with what comes out.
// Depends on plids_pkg.
module list_result_checker #(
	parameter int unsigned DEPTH = plids_pkg::DEPTH_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           in_valid,
	input  logic                           in_ready,
	input  logic [plids_pkg::OP_W-1:0]     opcode,
	input  plids_pkg::value_t              item_value,
	input  logic [plids_pkg::POS_W-1:0]    position,
	input  logic                           out_valid,
	input  logic                           out_ready,
	input  logic [plids_pkg::STAT_W-1:0]   status,
	input  logic [plids_pkg::FOUND_W-1:0]  found_position,
	input  logic [plids_pkg::LEN_W-1:0]    list_length,
	output int                             fail_count,
	output int                             results_pending
);
	import plids_pkg::*;

	typedef struct packed {
		logic [STAT_W-1:0]  status;
		logic [FOUND_W-1:0] found;
		logic [LEN_W-1:0]   len;
	} list_result_t;

	value_t       shadow_list [DEPTH];
	int unsigned  shadow_len = 0;
	list_result_t results_due [$];
	int           mismatches = 0;

	// Applies one request to the shadow list and returns the result it must give.
	function automatic list_result_t apply_request(logic [OP_W-1:0] op, value_t val,
			int unsigned pos);
		list_result_t res;
		int unsigned  i;
		logic         hit;
		res.status = ST_OK;
		res.found  = '0;
		hit = 1'b0;
		case (op)
			OP_INSERT: begin
				if (pos > shadow_len) begin
					res.status = ST_RANGE;
				end else if (shadow_len >= DEPTH) begin
					res.status = ST_FULL;
				end else begin
					for (i = shadow_len; i > pos; i--)
						shadow_list[i] = shadow_list[i - 1];
					shadow_list[pos] = val;
					shadow_len++;
				end
			end
			OP_DELETE: begin
				if (pos >= shadow_len) begin
					res.status = ST_RANGE;
				end else begin
					for (i = pos; i + 1 < shadow_len; i++)
						shadow_list[i] = shadow_list[i + 1];
					shadow_len--;
				end
			end
			OP_SEARCH: begin
				res.status = ST_NOTFOUND;
				for (i = 0; i < shadow_len; i++) begin
					if (!hit && shadow_list[i] == val) begin
						hit = 1'b1;
						res.status = ST_OK;
						res.found = i[FOUND_W-1:0];
					end
				end
			end
			default: begin
				// The unused opcode leaves the list alone and reports ok.
			end
		endcase
		res.len = shadow_len[LEN_W-1:0];
		return res;
	endfunction

	task automatic check_field(string field, int unsigned want, int unsigned got);
		if (want != got) begin
			$error("%s: expected %0d, got %0d", field, want, got);
			mismatches++;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin : watch
		list_result_t want;
		if (!arst_n) begin
			shadow_len = 0;
			results_due.delete();
			fail_count <= mismatches;
			results_pending <= 0;
		end else begin
			// Predict first, so a result that leaves in the accepting cycle still matches.
			if (in_valid && in_ready)
				results_due.push_back(apply_request(opcode, item_value, position));
			if (out_valid && out_ready) begin
				if (results_due.size() == 0) begin
					$error("unexpected result: status %0d found_position %0d list_length %0d",
						status, found_position, list_length);
					mismatches++;
				end else begin
					want = results_due.pop_front();
					check_field("status", want.status, status);
					check_field("found_position", want.found, found_position);
					check_field("list_length", want.len, list_length);
				end
			end
			fail_count <= mismatches;
			results_pending <= results_due.size();
		end
	end

endmodule

// ===== tb/positional_list_insert_delete_search_unit_test.sv =====
`timescale 1ns / 1ps
// Top of the positional list testbench: clock, reset, request stimulus and the
// receiver's ready pattern. Depends on plids_pkg, list_result_checker and the unit.
module positional_list_insert_delete_search_unit_test;
	import plids_pkg::*;

	localparam int unsigned DEPTH = DEPTH_DEF;
	// The fourth opcode has no name in the package; the unit must ignore it.
	localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;
	localparam int unsigned RANDOM_REQUESTS = 530;
	// Far beyond the slowest legal run with the 12 ns clock.
	localparam int unsigned RUN_LIMIT_NS = 5_000_000;

	// Request mixes for the random blocks: one grows the list until it is full,
	// one shrinks it back to empty, and one keeps it wandering around the middle.
	typedef enum int { MIX_FILL, MIX_BALANCED, MIX_EMPTY } op_mix_t;

	logic              clk;
	logic              arst_n;
	logic              in_valid;
	logic              in_ready;
	logic [OP_W-1:0]   opcode;
	value_t            item_value;
	logic [POS_W-1:0]  position;
	logic              out_valid;
	logic              out_ready;
	logic [STAT_W-1:0] status;
	logic [FOUND_W-1:0] found_position;
	logic [LEN_W-1:0]  list_length;

	int     fail_count;
	int     results_pending;
	logic   tx_throttle;
	logic   rx_throttle;
	int     stall_left;
	value_t value_pool [8];

	positional_list_insert_delete_search_unit #(.DEPTH(DEPTH)) dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready),
		.opcode(opcode), .item_value(item_value), .position(position),
		.out_valid(out_valid), .out_ready(out_ready),
		.status(status), .found_position(found_position), .list_length(list_length)
	);

	list_result_checker #(.DEPTH(DEPTH)) result_checker (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready),
		.opcode(opcode), .item_value(item_value), .position(position),
		.out_valid(out_valid), .out_ready(out_ready),
		.status(status), .found_position(found_position), .list_length(list_length),
		.fail_count(fail_count), .results_pending(results_pending)
	);

	always begin
		clk = 1'b0;
		#6;
		clk = 1'b1;
		#6;
	end

	// Receiver side. When throttled it drops ready now and then, sometimes for a
	// long stretch; otherwise it takes every result at once. The stall length
	// counts cycles with ready held low.
	always @(posedge clk) begin
		if (stall_left != 0) begin
			out_ready <= 1'b0;
			stall_left <= stall_left - 1;
		end else if (!rx_throttle) begin
			out_ready <= 1'b1;
		end else begin
			case ($urandom_range(19))
				0, 1, 2, 3: begin
					out_ready <= 1'b0;
					stall_left <= $urandom_range(2);
				end
				4: begin
					out_ready <= 1'b0;
					stall_left <= $urandom_range(30, 8);
				end
				default: out_ready <= 1'b1;
			endcase
		end
	end

	// Idle gap the sender leaves before a request when throttled: usually none,
	// often a short one, and once in a while a long pause.
	function automatic int sender_gap();
		int pick;
		if (!tx_throttle)
			return 0;
		pick = $urandom_range(99);
		if (pick < 65)
			return 0;
		if (pick < 92)
			return $urandom_range(3, 1);
		return $urandom_range(40, 8);
	endfunction

	// Drives one request and returns at the edge that accepts it. Valid is only
	// lowered when a gap follows, so back-to-back requests keep it high.
	task automatic send_request(input logic [OP_W-1:0] op, input value_t val,
			input logic [POS_W-1:0] pos);
		int gap;
		gap = sender_gap();
		if (gap != 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid   <= 1'b1;
		opcode     <= op;
		item_value <= val;
		position   <= pos;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
	endtask

	// Holds the sender off until every result the checker is waiting for has
	// come back, so the list is quiet before the next block starts.
	task automatic wait_until_drained();
		in_valid <= 1'b0;
		@(posedge clk);
		while (results_pending != 0)
			@(posedge clk);
	endtask

	// Values come mostly from a small pool, so searches hit and duplicates
	// appear; the rest are fully random and reach every bit of the field.
	function automatic value_t pick_value();
		if ($urandom_range(3) != 0)
			return value_pool[$urandom_range(7)];
		return value_t'($urandom);
	endfunction

	// Positions favor the head of the list, cover the whole list often, and
	// sometimes go past the deepest legal position.
	function automatic logic [POS_W-1:0] pick_position();
		int pick;
		pick = $urandom_range(99);
		if (pick < 55)
			return POS_W'($urandom_range(2));
		if (pick < 93)
			return POS_W'($urandom_range(DEPTH));
		return POS_W'($urandom_range(31, DEPTH + 1));
	endfunction

	task automatic random_request(input op_mix_t mix);
		int pick;
		int insert_pct;
		int delete_pct;
		case (mix)
			MIX_FILL: begin
				insert_pct = 70;
				delete_pct = 10;
			end
			MIX_EMPTY: begin
				insert_pct = 15;
				delete_pct = 60;
			end
			default: begin
				insert_pct = 40;
				delete_pct = 35;
			end
		endcase
		pick = $urandom_range(99);
		if (pick < insert_pct)
			send_request(OP_INSERT, pick_value(), pick_position());
		else if (pick < insert_pct + delete_pct)
			send_request(OP_DELETE, pick_value(), pick_position());
		else if (pick < 98)
			send_request(OP_SEARCH, pick_value(), POS_W'($urandom_range(31)));
		else
			send_request(OP_UNUSED, value_t'($urandom), POS_W'($urandom_range(31)));
	endtask

	initial begin
		int      sent;
		int      blk;
		int      count;
		op_mix_t mix;

		arst_n      = 1'b0;
		in_valid    = 1'b0;
		opcode      = OP_INSERT;
		item_value  = '0;
		position    = '0;
		out_ready   = 1'b0;
		stall_left  = 0;
		tx_throttle = 1'b1;
		rx_throttle = 1'b1;

		value_pool[0] = 32'sh8000_0000;
		value_pool[1] = 32'sh7fff_ffff;
		value_pool[2] = '0;
		value_pool[3] = -1;
		for (int i = 4; i < 8; i++)
			value_pool[i] = value_t'($urandom);

		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed requests. The empty list first: a search misses, a delete and
		// an insert past the end are both out of range, also with every position
		// bit set, and the unused opcode changes nothing.
		send_request(OP_SEARCH, '0, '0);
		send_request(OP_DELETE, '0, '0);
		send_request(OP_INSERT, 32'sd5, 5'd1);
		send_request(OP_INSERT, -1, 5'd31);
		send_request(OP_UNUSED, -1, 5'd31);
		// Build [-1, min, 0, max] through inserts at the end, the middle and the head.
		send_request(OP_INSERT, 32'sh8000_0000, 5'd0);
		send_request(OP_INSERT, 32'sh7fff_ffff, 5'd1);
		send_request(OP_INSERT, '0, 5'd1);
		send_request(OP_INSERT, -1, 5'd0);
		// Hits at the tail and the head, then a miss.
		send_request(OP_SEARCH, 32'sh7fff_ffff, 5'd17);
		send_request(OP_SEARCH, -1, '0);
		send_request(OP_SEARCH, 32'sd12345, '0);
		// A duplicate at the head: the search must report the first match.
		send_request(OP_INSERT, 32'sh7fff_ffff, 5'd0);
		send_request(OP_SEARCH, 32'sh7fff_ffff, '0);
		// Delete at the length is out of range; then the middle, the tail, the head.
		send_request(OP_DELETE, '0, 5'd5);
		send_request(OP_DELETE, '0, 5'd2);
		send_request(OP_DELETE, '0, 5'd3);
		send_request(OP_DELETE, '0, 5'd0);
		send_request(OP_UNUSED, '0, '0);
		// Position sixteen with two entries: the top position bit, out of range.
		send_request(OP_INSERT, 32'sd7, 5'd16);
		wait_until_drained();

		// Random blocks that cycle through the mixes so the list swings between
		// empty and full. Every fifth block runs with no idling on either side,
		// and every third one ends with the sender held off until it drains.
		sent = 0;
		blk = 0;
		while (sent < int'(RANDOM_REQUESTS)) begin
			case (blk % 4)
				0: mix = MIX_FILL;
				1: mix = MIX_BALANCED;
				2: mix = MIX_EMPTY;
				default: mix = op_mix_t'($urandom_range(2));
			endcase
			tx_throttle = (blk % 5 != 4);
			rx_throttle <= (blk % 5 != 4);
			count = $urandom_range(60, 30);
			// The last block is cut short so the total lands on the request budget.
			if (sent + count > int'(RANDOM_REQUESTS))
				count = int'(RANDOM_REQUESTS) - sent;
			repeat (count)
				random_request(mix);
			sent += count;
			if (blk % 3 == 2)
				wait_until_drained();
			blk++;
		end

		// Let the last results arrive, then give a search scan time to show any
		// stray result before the verdict.
		rx_throttle <= 1'b1;
		wait_until_drained();
		repeat (40) @(posedge clk);
		if (fail_count == 0 && results_pending == 0)
			$display("positional_list_insert_delete_search_unit_test: clean");
		else
			$display("positional_list_insert_delete_search_unit_test: errors");
		$finish;
	end

	initial begin
		#RUN_LIMIT_NS;
		$display("positional_list_insert_delete_search_unit_test: errors");
		$finish;
	end

endmodule
